>>> src/rjd_pkg.sv
`default_nettype none
package rjd_pkg;

  // field widths
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int KIND_W = 3;
  localparam int PCT_W  = 7;
  localparam int CNT_MAX = 511;

  // divider: dividend wide enough for done_count * 100
  localparam int DIV_W  = 16;
  localparam int DIV_CW = 4;
  localparam int PCT_SCALE = 100;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // event codes
  localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP        = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_URGENT_REQ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ITEM_DONE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_URGENT_DONE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_PERCENT     = 3'd6;

  // message kinds
  localparam logic [KIND_W-1:0] K_FETCH        = 3'd0;
  localparam logic [KIND_W-1:0] K_URGENT_FETCH = 3'd1;
  localparam logic [KIND_W-1:0] K_URGENT_READY = 3'd2;
  localparam logic [KIND_W-1:0] K_STOPPED      = 3'd3;
  localparam logic [KIND_W-1:0] K_PERCENT      = 3'd4;
  localparam logic [KIND_W-1:0] K_ALL_DONE     = 3'd5;

  // message index source
  localparam logic [2:0] SEL_ZERO = 3'd0;
  localparam logic [2:0] SEL_EVT  = 3'd1;
  localparam logic [2:0] SEL_CUR  = 3'd2;
  localparam logic [2:0] SEL_URG  = 3'd3;
  localparam logic [2:0] SEL_DEF  = 3'd4;
  localparam logic [2:0] SEL_CAND = 3'd5;

  // negative flag source
  localparam logic [1:0] NEG_ZERO = 2'd0;
  localparam logic [1:0] NEG_ONE  = 2'd1;
  localparam logic [1:0] NEG_FAIL = 2'd2;

  typedef struct packed {
    logic              load_evt;
    logic              clear_init;
    logic              clear_step;
    logic              stop_evt;
    logic              start_evt;
    logic              wrap_go;
    logic              pct_go;
    logic              cur_load;
    logic              start_tail;
    logic              urgent_hold;
    logic              urgent_clr;
    logic              wait_clr;
    logic              forget_clr;
    logic              ref_load;
    logic              ref_val;
    logic              rd_cand;
    logic              mark_write;
    logic              stop_report;
    logic              deferred_clr;
    logic              search_init;
    logic              search_step;
    logic              idle_set;
    logic              job_start;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [2:0]        idx_sel;
    logic [1:0]        neg_sel;
    logic              pct_sel;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             emit_ok;
    logic             doc_active;
    logic             forget;
    logic             stopping;
    logic             worker_idle;
    logic             waiting;
    logic             urgent_valid;
    logic             urgent_match;
    logic             deferred_valid;
    logic             rd_bit;
    logic             rem_zero;
    logic             clear_last;
    logic             div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> src/rjd_div.sv
`default_nettype none
module rjd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rjd_pkg::DIV_W-1:0]   dividend,
  input  logic [rjd_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [rjd_pkg::DIV_W-1:0]   quotient,
  output logic [rjd_pkg::CNT_W-1:0]   remainder
);
  import rjd_pkg::*;

  localparam logic [DIV_CW-1:0] STEP_LAST = DIV_CW'(DIV_W - 1);

  logic              busy;
  logic [DIV_CW-1:0] step;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {remainder, quotient[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIV_W-2:0], ge};
      remainder <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> src/rjd_datapath.sv
`default_nettype none
module rjd_datapath #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rjd_pkg::ACT_W-1:0]    action,
  input  logic [rjd_pkg::IDX_W-1:0]    item_index,
  input  logic                         item_failed,
  input  logic [rjd_pkg::CNT_W-1:0]    item_total,
  input  rjd_pkg::cmd_t                cmd,
  output rjd_pkg::stat_t               st,
  input  logic                         msg_stall,
  output logic                         msg_valid,
  output logic [rjd_pkg::KIND_W-1:0]   message_kind,
  output logic [rjd_pkg::IDX_W-1:0]    message_index,
  output logic                         negative_flag,
  output logic [rjd_pkg::PCT_W-1:0]    percent_value,
  output logic                         last_message
);
  import rjd_pkg::*;

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CAP = (MAX_ITEMS > CNT_MAX) ? CNT_MAX : MAX_ITEMS;
  localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_ITEMS - 1);
  localparam logic [CNT_W-1:0] TOTAL_CAP = CNT_W'(CAP);

  // latched event
  logic [ACT_W-1:0] ev_act;
  logic [IDX_W-1:0] ev_idx;
  logic             ev_failed;
  logic [CNT_W-1:0] ev_cnt;

  // dispatcher state
  logic             doc_active;
  logic [CNT_W-1:0] total_items;
  logic [CNT_W-1:0] done_count;
  logic             waiting_valid;
  logic             urgent_valid;
  logic [IDX_W-1:0] urgent_index;
  logic             deferred_valid;
  logic [IDX_W-1:0] deferred_index;
  logic             forget_flag;
  logic             stopping_flag;
  logic             worker_idle;

  // working registers
  logic             has_ref;
  logic [IDX_W-1:0] cur_idx;
  logic [CNT_W-1:0] cand;
  logic [CNT_W-1:0] remaining;
  logic [AW-1:0]    clr_cnt;

  // staged word, waiting to learn whether it is the last one
  logic              stg_valid;
  logic [KIND_W-1:0] stg_kind;
  logic [IDX_W-1:0]  stg_index;
  logic              stg_neg;
  logic [PCT_W-1:0]  stg_pct;

  logic done_mem [0:MAX_ITEMS-1];
  logic rd_bit;
  logic we;
  logic wdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_quo;
  logic [CNT_W-1:0] div_rem;

  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  cur_inc;
  logic [CNT_W-1:0]  cand_inc;
  logic [CNT_W-1:0]  cand_first;
  logic [DIV_W-1:0]  pct_prod;
  logic [PCT_W-1:0]  pct_clamped;
  logic [IDX_W-1:0]  emit_idx;
  logic              emit_neg;
  logic              out_free;
  logic              push;

  rjd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (total_items),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign pct_prod     = DIV_W'(done_count) * DIV_W'(PCT_SCALE);
  assign div_start    = cmd.wrap_go | cmd.pct_go;
  assign div_dividend = cmd.pct_go ? pct_prod : DIV_W'(ev_idx);
  assign pct_clamped  = (div_quo > DIV_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];

  always_comb begin
    if (ev_cnt == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (ev_cnt > TOTAL_CAP) begin
      cnt_eff = TOTAL_CAP;
    end else begin
      cnt_eff = ev_cnt;
    end
  end

  assign cur_inc    = CNT_W'(cur_idx) + CNT_W'(1);
  assign cand_inc   = cand + CNT_W'(1);
  assign cand_first = !has_ref ? '0 : ((cur_inc == total_items) ? '0 : cur_inc);

  always_comb begin
    case (cmd.idx_sel)
      SEL_EVT:  emit_idx = ev_idx;
      SEL_CUR:  emit_idx = cur_idx;
      SEL_URG:  emit_idx = urgent_index;
      SEL_DEF:  emit_idx = deferred_index;
      SEL_CAND: emit_idx = cand[IDX_W-1:0];
      default:  emit_idx = '0;
    endcase
  end

  always_comb begin
    case (cmd.neg_sel)
      NEG_ONE:  emit_neg = 1'b1;
      NEG_FAIL: emit_neg = ev_failed;
      default:  emit_neg = 1'b0;
    endcase
  end

  // done map: one write port, one registered read port
  assign we    = cmd.clear_step | cmd.mark_write;
  assign wdata = !cmd.clear_step;
  assign waddr = cmd.clear_step ? clr_cnt : AW'(cur_idx);
  assign raddr = cmd.rd_cand ? AW'(cand) : AW'(cur_idx);

  always_ff @(posedge clk) begin
    if (we) begin
      done_mem[waddr] <= wdata;
    end
    rd_bit <= done_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_evt) begin
      ev_act    <= action;
      ev_idx    <= item_index;
      ev_failed <= item_failed;
      ev_cnt    <= item_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      doc_active     <= 1'b0;
      total_items    <= '0;
      done_count     <= '0;
      waiting_valid  <= 1'b0;
      urgent_valid   <= 1'b0;
      urgent_index   <= '0;
      deferred_valid <= 1'b0;
      deferred_index <= '0;
      forget_flag    <= 1'b0;
      stopping_flag  <= 1'b0;
      worker_idle    <= 1'b0;
      has_ref        <= 1'b0;
      cur_idx        <= '0;
      cand           <= '0;
      remaining      <= '0;
      clr_cnt        <= '0;
      stg_valid      <= 1'b0;
    end else begin
      if (cmd.start_evt) begin
        total_items <= cnt_eff;
        done_count  <= '0;
        doc_active  <= 1'b1;
      end
      if (cmd.mark_write) begin
        done_count <= done_count + CNT_W'(1);
      end
      if (cmd.stop_evt) begin
        doc_active  <= 1'b0;
        forget_flag <= 1'b1;
        if (!worker_idle) begin
          stopping_flag <= 1'b1;
        end
      end
      if (cmd.start_tail) begin
        // a start during a job is deferred and the job's result dropped;
        // otherwise the job start in the same cycle wakes the worker
        if (waiting_valid) begin
          forget_flag    <= 1'b1;
          deferred_valid <= 1'b1;
          deferred_index <= cur_idx;
          worker_idle    <= 1'b0;
        end else begin
          forget_flag <= 1'b0;
        end
      end
      if (cmd.forget_clr) begin
        forget_flag <= 1'b0;
      end
      if (cmd.wait_clr) begin
        waiting_valid <= 1'b0;
      end
      if (cmd.urgent_hold) begin
        urgent_valid <= 1'b1;
        urgent_index <= cur_idx;
      end
      if (cmd.urgent_clr) begin
        urgent_valid <= 1'b0;
      end
      if (cmd.deferred_clr) begin
        deferred_valid <= 1'b0;
      end
      if (cmd.stop_report) begin
        stopping_flag <= 1'b0;
        worker_idle   <= 1'b1;
      end
      if (cmd.idle_set) begin
        worker_idle <= 1'b1;
      end
      if (cmd.job_start) begin
        waiting_valid <= 1'b1;
        worker_idle   <= 1'b0;
      end
      if (cmd.ref_load) begin
        has_ref <= cmd.ref_val;
      end
      if (cmd.cur_load) begin
        cur_idx <= div_rem[IDX_W-1:0];
      end
      if (cmd.search_init) begin
        cand      <= cand_first;
        remaining <= total_items - CNT_W'(has_ref);
      end else if (cmd.search_step) begin
        cand      <= (cand_inc == total_items) ? '0 : cand_inc;
        remaining <= remaining - CNT_W'(1);
      end
      if (cmd.clear_init) begin
        clr_cnt <= '0;
      end else if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.emit) begin
        stg_valid <= 1'b1;
      end else if (cmd.finish) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stg_kind  <= cmd.kind;
      stg_index <= emit_idx;
      stg_neg   <= emit_neg;
      stg_pct   <= cmd.pct_sel ? pct_clamped : '0;
    end
  end

  // output register: a new word pushes the staged one out
  assign out_free = !msg_valid || !msg_stall;
  assign push     = (cmd.emit | cmd.finish) & stg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (push) begin
      msg_valid <= 1'b1;
    end else if (!msg_stall) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      message_kind  <= stg_kind;
      message_index <= stg_index;
      negative_flag <= stg_neg;
      percent_value <= stg_pct;
      last_message  <= cmd.finish;
    end
  end

  always_comb begin
    st.act            = ev_act;
    st.emit_ok        = !stg_valid || out_free;
    st.doc_active     = doc_active;
    st.forget         = forget_flag;
    st.stopping       = stopping_flag;
    st.worker_idle    = worker_idle;
    st.waiting        = waiting_valid;
    st.urgent_valid   = urgent_valid;
    st.urgent_match   = has_ref && (cur_idx == urgent_index);
    st.deferred_valid = deferred_valid;
    st.rd_bit         = rd_bit;
    st.rem_zero       = (remaining == '0);
    st.clear_last     = (clr_cnt == CLR_LAST);
    st.div_done       = div_done;
  end

endmodule
`default_nettype wire

>>> src/rjd_ctrl.sv
`default_nettype none
module rjd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_stall,
  output rjd_pkg::cmd_t  cmd,
  input  rjd_pkg::stat_t st
);
  import rjd_pkg::*;

  localparam logic [4:0] S_RST_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DECODE    = 5'd2;
  localparam logic [4:0] S_CLEAR     = 5'd3;
  localparam logic [4:0] S_WRAP_GO   = 5'd4;
  localparam logic [4:0] S_WRAP_WAIT = 5'd5;
  localparam logic [4:0] S_START2    = 5'd6;
  localparam logic [4:0] S_UR_RD     = 5'd7;
  localparam logic [4:0] S_UR_CHK    = 5'd8;
  localparam logic [4:0] S_UD_EMIT   = 5'd9;
  localparam logic [4:0] S_MARK_RD   = 5'd10;
  localparam logic [4:0] S_MARK_CHK  = 5'd11;
  localparam logic [4:0] S_AFTER     = 5'd12;
  localparam logic [4:0] S_DEFER     = 5'd13;
  localparam logic [4:0] S_SRCH_RD   = 5'd14;
  localparam logic [4:0] S_SRCH_CHK  = 5'd15;
  localparam logic [4:0] S_PCT_GO    = 5'd16;
  localparam logic [4:0] S_PCT_WAIT  = 5'd17;
  localparam logic [4:0] S_PCT_EMIT  = 5'd18;
  localparam logic [4:0] S_FINISH    = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  assign evt_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_RST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (evt_valid) begin
          cmd.load_evt = 1'b1;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        if (st.emit_ok) begin
          case (st.act)
            ACT_STOP: begin
              cmd.stop_evt = 1'b1;
              if (st.worker_idle) begin
                cmd.emit = 1'b1;
                cmd.kind = K_STOPPED;
              end
              state_next = S_FINISH;
            end
            ACT_START: begin
              cmd.start_evt  = 1'b1;
              cmd.clear_init = 1'b1;
              state_next     = S_CLEAR;
            end
            ACT_URGENT_REQ: begin
              if (!st.doc_active) begin
                cmd.emit    = 1'b1;
                cmd.kind    = K_URGENT_READY;
                cmd.idx_sel = SEL_EVT;
                cmd.neg_sel = NEG_ONE;
                state_next  = S_FINISH;
              end else begin
                state_next = S_WRAP_GO;
              end
            end
            ACT_ITEM_DONE, ACT_URGENT_DONE: begin
              cmd.wait_clr = 1'b1;
              if (st.doc_active) begin
                cmd.ref_load = 1'b1;
                if (st.act == ACT_ITEM_DONE && st.forget) begin
                  // result of a forgotten job: no reference for the search
                  cmd.forget_clr = 1'b1;
                  cmd.ref_val    = 1'b0;
                  state_next     = S_AFTER;
                end else begin
                  cmd.ref_val = 1'b1;
                  state_next  = S_WRAP_GO;
                end
              end else begin
                if (st.stopping) begin
                  cmd.stop_report = 1'b1;
                  cmd.emit        = 1'b1;
                  cmd.kind        = K_STOPPED;
                end
                state_next = S_FINISH;
              end
            end
            ACT_PERCENT: begin
              if (st.doc_active) begin
                state_next = S_PCT_GO;
              end else begin
                cmd.emit   = 1'b1;
                cmd.kind   = K_PERCENT;
                state_next = S_FINISH;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_WRAP_GO;
        end
      end

      S_WRAP_GO: begin
        cmd.wrap_go = 1'b1;
        state_next  = S_WRAP_WAIT;
      end

      S_WRAP_WAIT: begin
        if (st.div_done) begin
          cmd.cur_load = 1'b1;
          case (st.act)
            ACT_START:       state_next = S_START2;
            ACT_URGENT_REQ:  state_next = S_UR_RD;
            ACT_ITEM_DONE:   state_next = S_MARK_RD;
            ACT_URGENT_DONE: state_next = S_UD_EMIT;
            default:         state_next = S_FINISH;
          endcase
        end
      end

      S_START2: begin
        if (st.emit_ok) begin
          cmd.start_tail = 1'b1;
          if (!st.waiting) begin
            cmd.job_start = 1'b1;
            cmd.emit      = 1'b1;
            cmd.kind      = K_FETCH;
            cmd.idx_sel   = SEL_CUR;
          end
          state_next = S_FINISH;
        end
      end

      S_UR_RD: begin
        state_next = S_UR_CHK;
      end

      S_UR_CHK: begin
        if (st.emit_ok) begin
          if (st.rd_bit) begin
            cmd.emit    = 1'b1;
            cmd.kind    = K_URGENT_READY;
            cmd.idx_sel = SEL_CUR;
          end else if (st.waiting) begin
            cmd.urgent_hold = 1'b1;
          end else begin
            cmd.urgent_clr = 1'b1;
            cmd.job_start  = 1'b1;
            cmd.emit       = 1'b1;
            cmd.kind       = K_URGENT_FETCH;
            cmd.idx_sel    = SEL_CUR;
          end
          state_next = S_FINISH;
        end
      end

      S_UD_EMIT: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.kind    = K_URGENT_READY;
          cmd.idx_sel = SEL_CUR;
          cmd.neg_sel = NEG_FAIL;
          state_next  = S_MARK_RD;
        end
      end

      S_MARK_RD: begin
        state_next = S_MARK_CHK;
      end

      S_MARK_CHK: begin
        if (!st.rd_bit) begin
          cmd.mark_write = 1'b1;
        end
        state_next = S_AFTER;
      end

      S_AFTER: begin
        if (st.emit_ok) begin
          if (st.stopping) begin
            cmd.stop_report = 1'b1;
            cmd.emit        = 1'b1;
            cmd.kind        = K_STOPPED;
            state_next      = S_FINISH;
          end else if (st.urgent_valid) begin
            cmd.urgent_clr = 1'b1;
            if (st.urgent_match) begin
              // the urgent item was the one just finished
              if (st.act != ACT_URGENT_DONE) begin
                cmd.emit    = 1'b1;
                cmd.kind    = K_URGENT_READY;
                cmd.idx_sel = SEL_CUR;
              end
              state_next = S_DEFER;
            end else begin
              cmd.job_start = 1'b1;
              cmd.emit      = 1'b1;
              cmd.kind      = K_URGENT_FETCH;
              cmd.idx_sel   = SEL_URG;
              state_next    = S_FINISH;
            end
          end else begin
            state_next = S_DEFER;
          end
        end
      end

      S_DEFER: begin
        if (st.emit_ok) begin
          if (st.deferred_valid) begin
            cmd.deferred_clr = 1'b1;
            cmd.job_start    = 1'b1;
            cmd.emit         = 1'b1;
            cmd.kind         = K_FETCH;
            cmd.idx_sel      = SEL_DEF;
            state_next       = S_FINISH;
          end else begin
            cmd.search_init = 1'b1;
            state_next      = S_SRCH_RD;
          end
        end
      end

      S_SRCH_RD: begin
        cmd.rd_cand = 1'b1;
        if (st.rem_zero) begin
          if (st.emit_ok) begin
            cmd.idle_set = 1'b1;
            cmd.emit     = 1'b1;
            cmd.kind     = K_ALL_DONE;
            state_next   = S_FINISH;
          end
        end else begin
          state_next = S_SRCH_CHK;
        end
      end

      S_SRCH_CHK: begin
        cmd.rd_cand = 1'b1;
        if (!st.rd_bit) begin
          if (st.emit_ok) begin
            cmd.job_start = 1'b1;
            cmd.emit      = 1'b1;
            cmd.kind      = K_FETCH;
            cmd.idx_sel   = SEL_CAND;
            state_next    = S_FINISH;
          end
        end else begin
          cmd.search_step = 1'b1;
          state_next      = S_SRCH_RD;
        end
      end

      S_PCT_GO: begin
        cmd.pct_go = 1'b1;
        state_next = S_PCT_WAIT;
      end

      S_PCT_WAIT: begin
        if (st.div_done) begin
          state_next = S_PCT_EMIT;
        end
      end

      S_PCT_EMIT: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.kind    = K_PERCENT;
          cmd.pct_sel = 1'b1;
          state_next  = S_FINISH;
        end
      end

      S_FINISH: begin
        // hand the staged word out marked last
        if (st.emit_ok) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/retrieval_job_dispatcher.sv
// One event is taken at a time; evt_stall is low only while the controller is idle.
// A start sweeps the done map clear first; a completion may search it entry by entry.
// Reset is synchronous; afterwards the done map is swept clear, during which no
// event is accepted.
`default_nettype none
module retrieval_job_dispatcher #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_stall,
  input  logic [rjd_pkg::ACT_W-1:0]    action,
  input  logic [rjd_pkg::IDX_W-1:0]    item_index,
  input  logic                         item_failed,
  input  logic [rjd_pkg::CNT_W-1:0]    item_total,
  output logic                         msg_valid,
  input  logic                         msg_stall,
  output logic [rjd_pkg::KIND_W-1:0]   message_kind,
  output logic [rjd_pkg::IDX_W-1:0]    message_index,
  output logic                         negative_flag,
  output logic [rjd_pkg::PCT_W-1:0]    percent_value,
  output logic                         last_message
);
  import rjd_pkg::*;

  cmd_t  cmd;
  stat_t st;

  rjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .cmd       (cmd),
    .st        (st)
  );

  rjd_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .item_index    (item_index),
    .item_failed   (item_failed),
    .item_total    (item_total),
    .cmd           (cmd),
    .st            (st),
    .msg_stall     (msg_stall),
    .msg_valid     (msg_valid),
    .message_kind  (message_kind),
    .message_index (message_index),
    .negative_flag (negative_flag),
    .percent_value (percent_value),
    .last_message  (last_message)
  );

endmodule
`default_nettype wire

>>> src/rjd_checker.sv
`default_nettype none
module rjd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         evt_valid,
  input logic                         evt_stall,
  input logic                         msg_valid,
  input logic                         msg_stall,
  input logic [rjd_pkg::KIND_W-1:0]   message_kind,
  input logic [rjd_pkg::IDX_W-1:0]    message_index,
  input logic                         negative_flag,
  input logic [rjd_pkg::PCT_W-1:0]    percent_value
);
  import rjd_pkg::*;

  // a stalled word stays on offer
  a_msg_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_stall |=> msg_valid)
    else $error("message dropped while stalled");

  // an accepted event keeps the input side closed while it is worked on
  a_evt_busy: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_stall |=> evt_stall)
    else $error("event accepted while the previous one is in progress");

  a_neg_kind: assert property (@(posedge clk) disable iff (rst)
    msg_valid && negative_flag |-> message_kind == K_URGENT_READY)
    else $error("negative flag on a message other than urgent ready");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    msg_valid && (message_kind == K_STOPPED || message_kind == K_PERCENT ||
                  message_kind == K_ALL_DONE) |-> message_index == '0)
    else $error("index carried on a message without one");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> (message_kind == K_PERCENT) ? (percent_value <= PCT_FULL)
                                              : (percent_value == '0))
    else $error("percent value out of range or on the wrong message");

endmodule

bind retrieval_job_dispatcher rjd_checker u_rjd_checker (.*);
`default_nettype wire

>>> tb/retrieval_job_dispatcher_tb.sv
`timescale 1ns / 1ps
module retrieval_job_dispatcher_tb;
  import rjd_pkg::*;

  localparam int DOC_LIMIT = 256;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              neg;
    logic [PCT_W-1:0]  pct;
    logic              last;
  } msg_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               evt_valid;
  logic               evt_stall;
  logic [ACT_W-1:0]   action;
  logic [IDX_W-1:0]   item_index;
  logic               item_failed;
  logic [CNT_W-1:0]   item_total;
  logic               msg_valid;
  logic               msg_stall = 1'b0;
  logic [KIND_W-1:0]  message_kind;
  logic [IDX_W-1:0]   message_index;
  logic               negative_flag;
  logic [PCT_W-1:0]   percent_value;
  logic               last_message;

  // dispatcher state as predicted
  bit   item_finished [DOC_LIMIT];
  bit   doc_open;
  bit   job_pending;
  bit   job_urgent;
  bit   urg_pending;
  bit   defer_pending;
  bit   drop_result;
  bit   stop_pending;
  bit   worker_free;
  int   item_count;
  int   finished_count;
  int   job_index;
  int   urg_index;
  int   defer_index;

  msg_t expected_msgs [$];
  msg_t step_msgs [$];
  int   mismatches = 0;
  int   burst_left = 0;
  int   stall_left = 0;
  int   stall_mode = 0;

  retrieval_job_dispatcher #(.MAX_ITEMS(DOC_LIMIT)) dut (
    .clk          (clk),
    .rst          (rst),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .action       (action),
    .item_index   (item_index),
    .item_failed  (item_failed),
    .item_total   (item_total),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .message_kind (message_kind),
    .message_index(message_index),
    .negative_flag(negative_flag),
    .percent_value(percent_value),
    .last_message (last_message)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(50_000_000);
    $display("[retrieval_job_dispatcher] ERROR");
    $finish;
  end

  function automatic void post_msg(input logic [KIND_W-1:0] kind, input int idx,
                                   input bit neg, input int pct);
    msg_t m;
    m.kind = kind;
    m.idx  = idx[IDX_W-1:0];
    m.neg  = neg;
    m.pct  = pct[PCT_W-1:0];
    m.last = 1'b0;
    if (step_msgs.size() < 2) step_msgs.push_back(m);
  endfunction

  function automatic int wrap_idx(input int idx);
    if (item_count == 0) return 0;
    return idx % item_count;
  endfunction

  function automatic void record_done(input int idx);
    if (idx < DOC_LIMIT && !item_finished[idx]) begin
      item_finished[idx] = 1'b1;
      finished_count = (finished_count + 1) & 'h1FF;
    end
  endfunction

  function automatic void launch_job(input int idx, input logic [KIND_W-1:0] kind);
    job_pending = 1'b1;
    job_index   = idx;
    job_urgent  = (kind == K_URGENT_FETCH);
    worker_free = 1'b0;
    post_msg(kind, idx, 1'b0, 0);
  endfunction

  function automatic void flush_stop();
    if (stop_pending) begin
      stop_pending = 1'b0;
      worker_free  = 1'b1;
      post_msg(K_STOPPED, 0, 1'b0, 0);
    end
  endfunction

  function automatic void pick_next_job(input bit has_ref, input int ref_idx,
                                        input bit ready_sent);
    int n;
    int cand;
    int base;
    if (urg_pending) begin
      urg_pending = 1'b0;
      if (has_ref && ref_idx == urg_index) begin
        if (!ready_sent) post_msg(K_URGENT_READY, ref_idx, 1'b0, 0);
      end else begin
        launch_job(urg_index, K_URGENT_FETCH);
        return;
      end
    end
    if (defer_pending) begin
      defer_pending = 1'b0;
      launch_job(defer_index, K_FETCH);
      return;
    end
    n = (item_count == 0) ? 1 : item_count;
    base = has_ref ? ref_idx : 0;
    // with no previous item the walk starts on index 0 itself
    for (int k = has_ref ? 1 : 0; k < n; k++) begin
      cand = (base + k) % n;
      if (cand < DOC_LIMIT && !item_finished[cand]) begin
        launch_job(cand, K_FETCH);
        return;
      end
    end
    post_msg(K_ALL_DONE, 0, 1'b0, 0);
    worker_free = 1'b1;
  endfunction

  function automatic void predict_event(input logic [ACT_W-1:0] act, input int idx,
                                        input bit failed, input int cnt);
    bit has_ref;
    int i;
    int pct;
    msg_t m;
    step_msgs.delete();
    case (act)
      ACT_STOP: begin
        doc_open = 1'b0;
        drop_result = 1'b1;
        if (worker_free) post_msg(K_STOPPED, 0, 1'b0, 0);
        else stop_pending = 1'b1;
      end
      ACT_START: begin
        if (cnt == 0) cnt = 1;
        if (cnt > DOC_LIMIT) cnt = DOC_LIMIT;
        item_count = cnt;
        finished_count = 0;
        doc_open = 1'b1;
        foreach (item_finished[j]) item_finished[j] = 1'b0;
        i = wrap_idx(idx);
        if (!job_pending) begin
          drop_result = 1'b0;
          launch_job(i, K_FETCH);
        end else begin
          // hold the new document's first item until the old job returns
          drop_result = 1'b1;
          defer_pending = 1'b1;
          defer_index = i;
        end
        worker_free = 1'b0;
      end
      ACT_URGENT_REQ: begin
        if (!doc_open) begin
          post_msg(K_URGENT_READY, idx, 1'b1, 0);
        end else begin
          i = wrap_idx(idx);
          if (item_finished[i]) begin
            post_msg(K_URGENT_READY, i, 1'b0, 0);
          end else if (job_pending) begin
            urg_pending = 1'b1;
            urg_index = i;
          end else begin
            urg_pending = 1'b0;
            launch_job(i, K_URGENT_FETCH);
          end
        end
      end
      ACT_ITEM_DONE: begin
        job_pending = 1'b0;
        if (doc_open) begin
          has_ref = 1'b0;
          i = idx;
          if (drop_result) begin
            drop_result = 1'b0;
          end else begin
            i = wrap_idx(idx);
            has_ref = 1'b1;
            record_done(i);
          end
          if (stop_pending) flush_stop();
          else pick_next_job(has_ref, i, 1'b0);
        end else begin
          flush_stop();
        end
      end
      ACT_URGENT_DONE: begin
        job_pending = 1'b0;
        if (doc_open) begin
          i = wrap_idx(idx);
          post_msg(K_URGENT_READY, i, failed, 0);
          record_done(i);
          if (stop_pending) flush_stop();
          else pick_next_job(1'b1, i, 1'b1);
        end else begin
          flush_stop();
        end
      end
      ACT_PERCENT: begin
        pct = 0;
        if (doc_open && item_count != 0) begin
          pct = finished_count * 100 / item_count;
          if (pct > 100) pct = 100;
        end
        post_msg(K_PERCENT, 0, 1'b0, pct);
      end
      default: ;
    endcase
    if (step_msgs.size() > 0) step_msgs[step_msgs.size() - 1].last = 1'b1;
    foreach (step_msgs[j]) begin
      m = step_msgs[j];
      expected_msgs.push_back(m);
    end
  endfunction

  // drive one event word; returns at a falling edge
  task automatic send_event(input logic [ACT_W-1:0] act, input int idx, input bit failed,
                            input int cnt);
    evt_valid   = 1'b1;
    action      = act;
    item_index  = idx[IDX_W-1:0];
    item_failed = failed;
    item_total  = cnt[CNT_W-1:0];
    do @(posedge clk); while (evt_stall);
    predict_event(act, idx[IDX_W-1:0], failed, cnt[CNT_W-1:0]);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      evt_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_for_drain();
    evt_valid = 1'b0;
    while (expected_msgs.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : take_msg
    msg_t want;
    if (!rst && msg_valid && !msg_stall) begin
      if (expected_msgs.size() == 0) begin
        mismatches++;
        $display("%0t: message kind %0d index %0d arrived with none expected",
                 $time, message_kind, message_index);
      end else begin
        want = expected_msgs.pop_front();
        check_field("message_kind", want.kind, message_kind);
        check_field("message_index", want.idx, message_index);
        check_field("negative_flag", want.neg, negative_flag);
        check_field("percent_value", want.pct, percent_value);
        check_field("last_message", want.last, last_message);
      end
    end
  end

  // receiver: runs of free flow, light stalls and heavy stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: msg_stall <= 1'b0;
      1: msg_stall <= ($urandom_range(0, 1) == 1);
      default: msg_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic test_no_document();
    send_event(ACT_UNUSED, 17, 1'b1, 3);
    send_event(ACT_PERCENT, 0, 1'b0, 0);
    send_event(ACT_URGENT_REQ, 255, 1'b0, 0);
    send_event(ACT_STOP, 0, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 9, 1'b0, 0);
    wait_for_drain();
  endtask

  task automatic test_item_count_clamp();
    send_event(ACT_START, 5, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 0, 1'b0, 0);
    send_event(ACT_START, 255, 1'b0, 511);
    send_event(ACT_ITEM_DONE, 255, 1'b1, 0);
    wait_for_drain();
  endtask

  task automatic test_deferred_and_urgent();
    send_event(ACT_START, 200, 1'b0, 3);
    send_event(ACT_ITEM_DONE, 0, 1'b0, 0);
    send_event(ACT_URGENT_REQ, 4, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 2, 1'b0, 0);
    send_event(ACT_URGENT_DONE, 1, 1'b1, 0);
    send_event(ACT_PERCENT, 0, 1'b0, 0);
    send_event(ACT_URGENT_REQ, 2, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 0, 1'b0, 0);
    wait_for_drain();
  endtask

  task automatic test_stop_paths();
    send_event(ACT_START, 3, 1'b0, 4);
    send_event(ACT_URGENT_REQ, 3, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 3, 1'b0, 0);
    send_event(ACT_STOP, 0, 1'b0, 0);
    send_event(ACT_START, 5, 1'b0, 4);
    send_event(ACT_ITEM_DONE, 0, 1'b0, 0);
    send_event(ACT_URGENT_REQ, 6, 1'b0, 0);
    send_event(ACT_URGENT_DONE, 2, 1'b0, 0);
    send_event(ACT_STOP, 0, 1'b0, 0);
    send_event(ACT_ITEM_DONE, 1, 1'b0, 0);
    send_event(ACT_STOP, 0, 1'b0, 0);
    wait_for_drain();
  endtask

  // mostly a well-behaved worker answering its jobs, with stray events mixed in
  task automatic test_random_traffic(input int count);
    int sent;
    int roll;
    int pick;
    int idx;
    int total;
    bit paused;
    logic [ACT_W-1:0] act;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      roll  = $urandom_range(0, 99);
      idx   = $urandom_range(0, 255);
      total = $urandom_range(0, 511);
      if (roll < 5 || (!doc_open && roll < 80) || (doc_open && !job_pending && roll < 30)) begin
        act = ACT_START;
        pick = $urandom_range(0, 9);
        if (pick == 0) total = 0;
        else if (pick == 1) total = $urandom_range(13, 256);
        else if (pick == 2) total = $urandom_range(257, 511);
        else total = $urandom_range(1, 12);
      end else if (job_pending && roll < 75) begin
        act = job_urgent ? ACT_URGENT_DONE : ACT_ITEM_DONE;
        if ($urandom_range(0, 9) == 0) act = job_urgent ? ACT_ITEM_DONE : ACT_URGENT_DONE;
        idx = job_index;
        // an index past the count names the same item once wrapped
        if ($urandom_range(0, 7) == 0) idx = job_index + item_count * $urandom_range(1, 3);
        if (idx > 255) idx = job_index;
      end else if (roll < 82) begin
        act = ACT_URGENT_REQ;
      end else if (roll < 88) begin
        act = ACT_PERCENT;
      end else if (roll < 92) begin
        act = ACT_STOP;
      end else if (roll < 96) begin
        act = ($urandom_range(0, 1) == 1) ? ACT_ITEM_DONE : ACT_URGENT_DONE;
      end else begin
        act = ($urandom_range(0, 1) == 1) ? ACT_NONE : ACT_UNUSED;
      end
      send_event(act, idx, $urandom_range(0, 3) == 0, total);
      if (act != ACT_NONE && act != ACT_UNUSED) sent++;
      if (!paused && sent >= count / 2) begin
        paused = 1'b1;
        wait_for_drain();
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    evt_valid   = 1'b0;
    action      = ACT_NONE;
    item_index  = '0;
    item_failed = 1'b0;
    item_total  = '0;
    item_count = 0;
    finished_count = 0;
    job_index = 0;
    urg_index = 0;
    defer_index = 0;
    foreach (item_finished[j]) item_finished[j] = 1'b0;
    {doc_open, job_pending, job_urgent, urg_pending, defer_pending} = '0;
    {drop_result, stop_pending, worker_free} = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_no_document();
    test_item_count_clamp();
    test_deferred_and_urgent();
    test_stop_paths();
    test_random_traffic(1000);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_msgs.size() == 0) begin
      $display("[retrieval_job_dispatcher] OK");
    end else begin
      $display("[retrieval_job_dispatcher] ERROR");
    end
    $finish;
  end

endmodule
